### src/gn2d_pkg.sv
// Shared constants, types and codes of the 2-D gradient noise unit.
`default_nettype none

package gn2d_pkg;

  localparam int LATTICE_SIDE = 3;
  localparam int MAX_DIM      = 4096;

  localparam int PIX_W   = 12;
  localparam int GRAD_W  = 16;
  localparam int OUT_W   = 16;
  localparam int LAT_W   = 2;
  localparam int CFG_W   = 13;
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int CMP_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int FRAC_W  = 16;
  localparam int NUM5_W  = PIX_W + 3;
  localparam int NUM_W   = NUM5_W + 14;
  localparam int CELL_W  = NUM_W - FRAC_W;
  localparam int IDX_W   = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
  localparam int TAB_N   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int TAB_AW  = $clog2(TAB_N);
  localparam int RECIP   = (2 ** 16) / LATTICE_SIDE;
  localparam int RECIP_W = 17;
  localparam int SM_W    = 17;

  localparam int SPLIT_LAT = NUM_W + CELL_W + 2;
  localparam int BLEND_LAT = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic                     is_eval;
    logic [TAB_AW-1:0]        addr;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [NUM5_W-1:0]        px5;
    logic [NUM5_W-1:0]        py5;
  } item_t;

  typedef struct packed {
    logic                     is_eval;
    logic [TAB_AW-1:0]        addr;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } ctl_t;

  typedef struct packed {
    logic                     we;
    logic [TAB_AW-1:0]        addr;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } tab_wr_t;

endpackage

`default_nettype wire

### src/gn2d_front.sv
// Front end: accepts words, drops loads outside the table and queues the rest.
`default_nettype none

module gn2d_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [gn2d_pkg::LAT_W-1:0]          in_lattice_x,
  input  logic [gn2d_pkg::LAT_W-1:0]          in_lattice_y,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  in_grad_x,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  in_grad_y,
  input  logic [gn2d_pkg::PIX_W-1:0]          in_pixel_x,
  input  logic [gn2d_pkg::PIX_W-1:0]          in_pixel_y,
  input  logic                                pop_en,
  output logic                                head_valid,
  output gn2d_pkg::item_t                     head
);

  gn2d_pkg::item_t                    q_r [gn2d_pkg::FIFO_DEPTH];
  logic [gn2d_pkg::FIFO_AW-1:0]       wptr_r, wptr_nxt;
  logic [gn2d_pkg::FIFO_AW-1:0]       rptr_r, rptr_nxt;
  logic [gn2d_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               keep, push, pop;
  gn2d_pkg::item_t                    item;

  assign in_ready   = (cnt_r != gn2d_pkg::CNT_W'(gn2d_pkg::FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rptr_r];

  always_comb begin
    keep = (in_command == gn2d_pkg::CMD_EVAL) ||
           ((32'(in_lattice_x) < gn2d_pkg::LATTICE_SIDE) &&
            (32'(in_lattice_y) < gn2d_pkg::LATTICE_SIDE));
    push = in_valid && in_ready && keep;
    pop  = pop_en && head_valid;
    item.is_eval = (in_command == gn2d_pkg::CMD_EVAL);
    item.addr    = gn2d_pkg::TAB_AW'(32'(in_lattice_y) * gn2d_pkg::LATTICE_SIDE +
                                     32'(in_lattice_x));
    item.gx      = in_grad_x;
    item.gy      = in_grad_y;
    // Five times the pixel, as shift and add.
    item.px5     = gn2d_pkg::NUM5_W'({in_pixel_x, 2'b00}) + gn2d_pkg::NUM5_W'(in_pixel_x);
    item.py5     = gn2d_pkg::NUM5_W'({in_pixel_y, 2'b00}) + gn2d_pkg::NUM5_W'(in_pixel_y);
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + gn2d_pkg::CNT_W'(push) - gn2d_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

### src/gn2d_split.sv
// One axis: pipelined scale division, cell wrap modulo the map size and lattice index.
`default_nettype none

module gn2d_split (
  input  logic                               clk,
  input  logic                               en,
  input  logic [gn2d_pkg::DIM_W-1:0]         dim,
  input  logic [gn2d_pkg::NUM5_W-1:0]        num5,
  output logic [gn2d_pkg::IDX_W-1:0]         col0,
  output logic [gn2d_pkg::IDX_W-1:0]         col1,
  output logic [gn2d_pkg::FRAC_W-1:0]        frac
);

  // Restoring division, one quotient bit per stage.
  logic [gn2d_pkg::DIM_W-1:0]  drem_r   [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::NUM_W-1:0]  dnum_r   [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::NUM_W-1:0]  dquo_r   [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::DIM_W-1:0]  drem_nxt [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::NUM_W-1:0]  dnum_nxt [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::NUM_W-1:0]  dquo_nxt [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::DIM_W-1:0]  d_prem   [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::NUM_W-1:0]  d_pnum   [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::NUM_W-1:0]  d_pquo   [gn2d_pkg::NUM_W];
  logic [gn2d_pkg::DIM_W:0]    d_trial  [gn2d_pkg::NUM_W];
  logic                        d_ge     [gn2d_pkg::NUM_W];

  // Remainder of the cell by the map size, one cell bit per stage.
  logic [gn2d_pkg::DIM_W-1:0]  mrem_r   [gn2d_pkg::CELL_W];
  logic [gn2d_pkg::CELL_W-1:0] mcell_r  [gn2d_pkg::CELL_W];
  logic [gn2d_pkg::FRAC_W-1:0] mfrac_r  [gn2d_pkg::CELL_W];
  logic [gn2d_pkg::DIM_W-1:0]  mrem_nxt [gn2d_pkg::CELL_W];
  logic [gn2d_pkg::CELL_W-1:0] mcell_nxt[gn2d_pkg::CELL_W];
  logic [gn2d_pkg::FRAC_W-1:0] mfrac_nxt[gn2d_pkg::CELL_W];
  logic [gn2d_pkg::DIM_W-1:0]  m_prem   [gn2d_pkg::CELL_W];
  logic [gn2d_pkg::CELL_W-1:0] m_pcell  [gn2d_pkg::CELL_W];
  logic [gn2d_pkg::DIM_W:0]    m_trial  [gn2d_pkg::CELL_W];
  logic                        m_ge     [gn2d_pkg::CELL_W];

  logic [gn2d_pkg::DIM_W-1:0]  x0, x1;
  logic [gn2d_pkg::DIM_W:0]    x1s;
  logic [gn2d_pkg::DIM_W+gn2d_pkg::RECIP_W-1:0] prod0, prod1;
  logic [gn2d_pkg::DIM_W-1:0]  v0_r, v1_r, q0_r, q1_r;
  logic [gn2d_pkg::FRAC_W-1:0] wfrac_r;
  logic [gn2d_pkg::DIM_W-1:0]  r0, r1;
  logic [gn2d_pkg::IDX_W-1:0]  col0_r, col1_r, col0_nxt, col1_nxt;
  logic [gn2d_pkg::FRAC_W-1:0] frac_r;

  always_comb begin
    for (int i = 0; i < gn2d_pkg::NUM_W; i++) begin
      if (i == 0) begin
        d_prem[i] = '0;
        d_pnum[i] = gn2d_pkg::NUM_W'(num5) << (gn2d_pkg::NUM_W - gn2d_pkg::NUM5_W);
        d_pquo[i] = '0;
      end else begin
        d_prem[i] = drem_r[i-1];
        d_pnum[i] = dnum_r[i-1];
        d_pquo[i] = dquo_r[i-1];
      end
      d_trial[i]  = {d_prem[i], d_pnum[i][gn2d_pkg::NUM_W-1]};
      d_ge[i]     = (d_trial[i] >= {1'b0, dim});
      drem_nxt[i] = d_ge[i] ? gn2d_pkg::DIM_W'(d_trial[i] - {1'b0, dim})
                            : d_trial[i][gn2d_pkg::DIM_W-1:0];
      dnum_nxt[i] = d_pnum[i] << 1;
      dquo_nxt[i] = {d_pquo[i][gn2d_pkg::NUM_W-2:0], d_ge[i]};
    end
  end

  always_comb begin
    for (int j = 0; j < gn2d_pkg::CELL_W; j++) begin
      if (j == 0) begin
        m_prem[j]    = '0;
        m_pcell[j]   = dquo_r[gn2d_pkg::NUM_W-1][gn2d_pkg::NUM_W-1:gn2d_pkg::FRAC_W];
        mfrac_nxt[j] = dquo_r[gn2d_pkg::NUM_W-1][gn2d_pkg::FRAC_W-1:0];
      end else begin
        m_prem[j]    = mrem_r[j-1];
        m_pcell[j]   = mcell_r[j-1];
        mfrac_nxt[j] = mfrac_r[j-1];
      end
      m_trial[j]   = {m_prem[j], m_pcell[j][gn2d_pkg::CELL_W-1]};
      m_ge[j]      = (m_trial[j] >= {1'b0, dim});
      mrem_nxt[j]  = m_ge[j] ? gn2d_pkg::DIM_W'(m_trial[j] - {1'b0, dim})
                             : m_trial[j][gn2d_pkg::DIM_W-1:0];
      mcell_nxt[j] = m_pcell[j] << 1;
    end
  end

  always_comb begin
    x0  = mrem_r[gn2d_pkg::CELL_W-1];
    x1s = {1'b0, x0} + 1'b1;
    // The next cell wraps to zero at the map edge.
    x1  = (x1s == {1'b0, dim}) ? '0 : x1s[gn2d_pkg::DIM_W-1:0];
    prod0 = (gn2d_pkg::DIM_W + gn2d_pkg::RECIP_W)'(x0) *
            (gn2d_pkg::DIM_W + gn2d_pkg::RECIP_W)'(gn2d_pkg::RECIP);
    prod1 = (gn2d_pkg::DIM_W + gn2d_pkg::RECIP_W)'(x1) *
            (gn2d_pkg::DIM_W + gn2d_pkg::RECIP_W)'(gn2d_pkg::RECIP);
    // The reciprocal quotient may fall one short, so one correction follows.
    r0 = v0_r - gn2d_pkg::DIM_W'(q0_r * gn2d_pkg::DIM_W'(gn2d_pkg::LATTICE_SIDE));
    r1 = v1_r - gn2d_pkg::DIM_W'(q1_r * gn2d_pkg::DIM_W'(gn2d_pkg::LATTICE_SIDE));
    col0_nxt = (r0 >= gn2d_pkg::DIM_W'(gn2d_pkg::LATTICE_SIDE))
             ? gn2d_pkg::IDX_W'(r0 - gn2d_pkg::DIM_W'(gn2d_pkg::LATTICE_SIDE))
             : gn2d_pkg::IDX_W'(r0);
    col1_nxt = (r1 >= gn2d_pkg::DIM_W'(gn2d_pkg::LATTICE_SIDE))
             ? gn2d_pkg::IDX_W'(r1 - gn2d_pkg::DIM_W'(gn2d_pkg::LATTICE_SIDE))
             : gn2d_pkg::IDX_W'(r1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < gn2d_pkg::NUM_W; i++) begin
        drem_r[i] <= drem_nxt[i];
        dnum_r[i] <= dnum_nxt[i];
        dquo_r[i] <= dquo_nxt[i];
      end
      for (int j = 0; j < gn2d_pkg::CELL_W; j++) begin
        mrem_r[j]  <= mrem_nxt[j];
        mcell_r[j] <= mcell_nxt[j];
        mfrac_r[j] <= mfrac_nxt[j];
      end
      v0_r    <= x0;
      v1_r    <= x1;
      q0_r    <= prod0[gn2d_pkg::DIM_W+15:16];
      q1_r    <= prod1[gn2d_pkg::DIM_W+15:16];
      wfrac_r <= mfrac_r[gn2d_pkg::CELL_W-1];
      col0_r  <= col0_nxt;
      col1_r  <= col1_nxt;
      frac_r  <= wfrac_r;
    end
  end

  assign col0 = col0_r;
  assign col1 = col1_r;
  assign frac = frac_r;

endmodule

`default_nettype wire

### src/gn2d_gtab.sv
// Gradient table: one copy per corner, cleared at reset through per-entry valid bits.
`default_nettype none

module gn2d_gtab (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  gn2d_pkg::tab_wr_t                  wr,
  input  logic [gn2d_pkg::IDX_W-1:0]         col0,
  input  logic [gn2d_pkg::IDX_W-1:0]         col1,
  input  logic [gn2d_pkg::IDX_W-1:0]         row0,
  input  logic [gn2d_pkg::IDX_W-1:0]         row1,
  output logic signed [gn2d_pkg::GRAD_W-1:0] gx [4],
  output logic signed [gn2d_pkg::GRAD_W-1:0] gy [4]
);

  logic [2*gn2d_pkg::GRAD_W-1:0] mem_r [4][gn2d_pkg::TAB_N];
  logic                          vld_r [gn2d_pkg::TAB_N];
  logic [2*gn2d_pkg::GRAD_W-1:0] rd_r  [4];
  logic                          rdv_r [4];
  logic [gn2d_pkg::TAB_AW-1:0]   ra    [4];

  always_comb begin
    ra[0] = gn2d_pkg::TAB_AW'(32'(row0) * gn2d_pkg::LATTICE_SIDE + 32'(col0));
    ra[1] = gn2d_pkg::TAB_AW'(32'(row0) * gn2d_pkg::LATTICE_SIDE + 32'(col1));
    ra[2] = gn2d_pkg::TAB_AW'(32'(row1) * gn2d_pkg::LATTICE_SIDE + 32'(col0));
    ra[3] = gn2d_pkg::TAB_AW'(32'(row1) * gn2d_pkg::LATTICE_SIDE + 32'(col1));
    for (int k = 0; k < 4; k++) begin
      gx[k] = rdv_r[k] ? $signed(rd_r[k][2*gn2d_pkg::GRAD_W-1:gn2d_pkg::GRAD_W]) : '0;
      gy[k] = rdv_r[k] ? $signed(rd_r[k][gn2d_pkg::GRAD_W-1:0]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < gn2d_pkg::TAB_N; e++) begin
        vld_r[e] <= 1'b0;
      end
    end else if (en && wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        if (wr.we) begin
          mem_r[k][wr.addr] <= {wr.gx, wr.gy};
        end
        rd_r[k]  <= mem_r[k][ra[k]];
        rdv_r[k] <= vld_r[ra[k]];
      end
    end
  end

endmodule

`default_nettype wire

### src/gn2d_blend.sv
// Back end arithmetic: corner dot products, smoothstep weights, two lerp levels, saturation.
`default_nettype none

module gn2d_blend (
  input  logic                               clk,
  input  logic                               en,
  input  logic [gn2d_pkg::FRAC_W-1:0]        fx,
  input  logic [gn2d_pkg::FRAC_W-1:0]        fy,
  input  logic signed [gn2d_pkg::GRAD_W-1:0] gx [4],
  input  logic signed [gn2d_pkg::GRAD_W-1:0] gy [4],
  output logic signed [gn2d_pkg::OUT_W-1:0]  noise
);

  logic [gn2d_pkg::FRAC_W-1:0] f0x_r, f0y_r, t2x_r, t2y_r;
  logic [2*gn2d_pkg::FRAC_W-1:0] sqx, sqy;
  logic [17:0]                 mx, my;
  logic [33:0]                 spx, spy;
  logic signed [16:0]          dx [4];
  logic signed [16:0]          dy [4];
  logic signed [32:0]          p_r [8];
  logic [gn2d_pkg::SM_W-1:0]   sx_r, sy_r, sx2_r, sy2_r, sy3_r, sy4_r;
  logic signed [33:0]          d_r [4];
  logic signed [34:0]          dt, db;
  logic signed [52:0]          pt_r, pb_r;
  logic signed [33:0]          at_r, ab_r;
  logic signed [34:0]          top_r, bot_r, top5_r;
  logic signed [35:0]          d2;
  logic signed [53:0]          p2_r;
  logic signed [36:0]          res, v;

  always_comb begin
    sqx = 32'(fx) * 32'(fx);
    sqy = 32'(fy) * 32'(fy);
    mx  = 18'(196608) - 18'({f0x_r, 1'b0});
    my  = 18'(196608) - 18'({f0y_r, 1'b0});
    spx = 34'(t2x_r) * 34'(mx);
    spy = 34'(t2y_r) * 34'(my);
    // Offsets towards the far corner are the fraction minus one: a set top bit.
    for (int k = 0; k < 4; k++) begin
      dx[k] = $signed({(k % 2 == 1), f0x_r});
      dy[k] = $signed({(k / 2 == 1), f0y_r});
    end
    dt  = 35'(d_r[1]) - 35'(d_r[0]);
    db  = 35'(d_r[3]) - 35'(d_r[2]);
    d2  = 36'(bot_r) - 36'(top_r);
    res = 37'(top5_r) + 37'(p2_r >>> 16);
    v   = res >>> 16;
    if (v > 37'sd32767) begin
      noise = 16'sh7FFF;
    end else if (v < -37'sd32768) begin
      noise = 16'sh8000;
    end else begin
      noise = v[gn2d_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0x_r <= fx;
      f0y_r <= fy;
      t2x_r <= sqx[2*gn2d_pkg::FRAC_W-1:gn2d_pkg::FRAC_W];
      t2y_r <= sqy[2*gn2d_pkg::FRAC_W-1:gn2d_pkg::FRAC_W];
      for (int k = 0; k < 4; k++) begin
        p_r[2*k]   <= 33'(gx[k]) * 33'(dx[k]);
        p_r[2*k+1] <= 33'(gy[k]) * 33'(dy[k]);
      end
      sx_r <= spx[32:16];
      sy_r <= spy[32:16];
      for (int k = 0; k < 4; k++) begin
        d_r[k] <= 34'(p_r[2*k]) + 34'(p_r[2*k+1]);
      end
      sx2_r <= sx_r;
      sy2_r <= sy_r;
      pt_r  <= 53'(dt) * 53'($signed({1'b0, sx2_r}));
      pb_r  <= 53'(db) * 53'($signed({1'b0, sx2_r}));
      at_r  <= d_r[0];
      ab_r  <= d_r[2];
      sy3_r <= sy2_r;
      top_r <= 35'(at_r) + 35'(pt_r >>> 16);
      bot_r <= 35'(ab_r) + 35'(pb_r >>> 16);
      sy4_r <= sy3_r;
      p2_r   <= 54'(d2) * 54'($signed({1'b0, sy4_r}));
      top5_r <= top_r;
    end
  end

endmodule

`default_nettype wire

### src/gradient_noise_2d_unit.sv
// Top level of the 2-D gradient noise unit: configuration, back-end control and output register.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | command, lattice x/y, gradient x/y, pixel x/y
//  out     | output    | out_valid/out_ready  | noise_value
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One word is taken per cycle while the front queue has room; only evaluate words give a result.
// Most of the pipeline is the per-axis divider, which retires one quotient bit per stage.
// Reset clears the gradient table at once through per-entry valid bits; no clearing pass.
// A full output register stalls the whole back end; the four-entry front queue keeps taking
// words until it fills.
`default_nettype none

module gradient_noise_2d_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [gn2d_pkg::LAT_W-1:0]         in_lattice_x,
  input  logic [gn2d_pkg::LAT_W-1:0]         in_lattice_y,
  input  logic signed [gn2d_pkg::GRAD_W-1:0] in_grad_x,
  input  logic signed [gn2d_pkg::GRAD_W-1:0] in_grad_y,
  input  logic [gn2d_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [gn2d_pkg::PIX_W-1:0]         in_pixel_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gn2d_pkg::OUT_W-1:0]  out_noise_value,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [gn2d_pkg::CFG_W-1:0]         cfg_data
);

  localparam int T = gn2d_pkg::SPLIT_LAT - 1;

  logic [gn2d_pkg::CFG_W-1:0] width_r, height_r;
  logic [gn2d_pkg::DIM_W-1:0] eff_w, eff_h;
  logic                       en;
  logic                       head_valid;
  gn2d_pkg::item_t            head;
  logic                       vld_r [gn2d_pkg::SPLIT_LAT];
  gn2d_pkg::ctl_t             ctl_r [gn2d_pkg::SPLIT_LAT];
  logic                       bv_r  [gn2d_pkg::BLEND_LAT];
  logic [gn2d_pkg::IDX_W-1:0] x0c, x1c, y0c, y1c;
  logic [gn2d_pkg::FRAC_W-1:0] fx, fy;
  gn2d_pkg::tab_wr_t          tab_wr;
  logic signed [gn2d_pkg::GRAD_W-1:0] gx [4];
  logic signed [gn2d_pkg::GRAD_W-1:0] gy [4];
  logic signed [gn2d_pkg::OUT_W-1:0]  noise;
  logic                       out_valid_r;
  logic signed [gn2d_pkg::OUT_W-1:0]  out_noise_r;

  // A size of zero acts as one, and sizes above the maximum are clamped.
  always_comb begin
    if (width_r == '0) begin
      eff_w = gn2d_pkg::DIM_W'(1);
    end else if (gn2d_pkg::CMP_W'(width_r) > gn2d_pkg::CMP_W'(gn2d_pkg::MAX_DIM)) begin
      eff_w = gn2d_pkg::DIM_W'(gn2d_pkg::MAX_DIM);
    end else begin
      eff_w = gn2d_pkg::DIM_W'(width_r);
    end
    if (height_r == '0) begin
      eff_h = gn2d_pkg::DIM_W'(1);
    end else if (gn2d_pkg::CMP_W'(height_r) > gn2d_pkg::CMP_W'(gn2d_pkg::MAX_DIM)) begin
      eff_h = gn2d_pkg::DIM_W'(gn2d_pkg::MAX_DIM);
    end else begin
      eff_h = gn2d_pkg::DIM_W'(height_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gn2d_pkg::DIM_RESET;
      height_r <= gn2d_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gn2d_pkg::CFG_MAP_WIDTH:  width_r  <= cfg_data;
        gn2d_pkg::CFG_MAP_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !out_valid_r || out_ready;

  gn2d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_lattice_x (in_lattice_x),
    .in_lattice_y (in_lattice_y),
    .in_grad_x    (in_grad_x),
    .in_grad_y    (in_grad_y),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .pop_en       (en),
    .head_valid   (head_valid),
    .head         (head)
  );

  gn2d_split u_split_x (
    .clk  (clk),
    .en   (en),
    .dim  (eff_w),
    .num5 (head.px5),
    .col0 (x0c),
    .col1 (x1c),
    .frac (fx)
  );

  gn2d_split u_split_y (
    .clk  (clk),
    .en   (en),
    .dim  (eff_h),
    .num5 (head.py5),
    .col0 (y0c),
    .col1 (y1c),
    .frac (fy)
  );

  // Loads ride the same pipeline as evaluates so table updates keep word order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gn2d_pkg::SPLIT_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
      for (int b = 0; b < gn2d_pkg::BLEND_LAT; b++) begin
        bv_r[b] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= head_valid;
      for (int i = 1; i < gn2d_pkg::SPLIT_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      bv_r[0] <= vld_r[T] && ctl_r[T].is_eval;
      for (int b = 1; b < gn2d_pkg::BLEND_LAT; b++) begin
        bv_r[b] <= bv_r[b-1];
      end
      out_valid_r <= bv_r[gn2d_pkg::BLEND_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0].is_eval <= head.is_eval;
      ctl_r[0].addr    <= head.addr;
      ctl_r[0].gx      <= head.gx;
      ctl_r[0].gy      <= head.gy;
      for (int i = 1; i < gn2d_pkg::SPLIT_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_noise_r <= noise;
    end
  end

  always_comb begin
    tab_wr.we   = vld_r[T] && !ctl_r[T].is_eval;
    tab_wr.addr = ctl_r[T].addr;
    tab_wr.gx   = ctl_r[T].gx;
    tab_wr.gy   = ctl_r[T].gy;
  end

  gn2d_gtab u_gtab (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .wr    (tab_wr),
    .col0  (x0c),
    .col1  (x1c),
    .row0  (y0c),
    .row1  (y1c),
    .gx    (gx),
    .gy    (gy)
  );

  gn2d_blend u_blend (
    .clk   (clk),
    .en    (en),
    .fx    (fx),
    .fy    (fy),
    .gx    (gx),
    .gy    (gy),
    .noise (noise)
  );

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output word valid after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[T]) && $stable(bv_r[gn2d_pkg::BLEND_LAT-1]))
    else $error("back end moved while the output register was held");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[T] && !ctl_r[T].is_eval |=> !bv_r[0])
    else $error("a gradient load entered the blend stages");

  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> head_valid)
    else $error("input refused while the queue is empty");

endmodule

`default_nettype wire
